/* hw/rtl/bmprle_pkg.sv */
// ----------------------------------------------------------------------------
// bmprle_pkg
// Shared types, constants and color conversion for the BMP RLE8 line decoder.
// ----------------------------------------------------------------------------
package bmprle_pkg;

  localparam int unsigned DISPLAY_WIDTH_DEF  = 480;
  localparam int unsigned DISPLAY_HEIGHT_DEF = 320;
  localparam int unsigned PALETTE_DEPTH_DEF  = 256;

  localparam logic [15:0] WHITE565      = 16'hFFFF;
  localparam logic [15:0] COL_MAX       = 16'hFFFF;
  localparam logic [13:0] ROWS_MAX      = 14'h3FFF;
  localparam logic [13:0] WIDTH_RESET   = 14'd480;
  localparam logic [13:0] HEIGHT_RESET  = 14'd320;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PALETTE = 2'd1,
    OP_DATA    = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_TRUE   = 2'd2,
    CFG_RLE    = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    PH_FIRST  = 4'd0,
    PH_SECOND = 4'd1,
    PH_DX     = 4'd2,
    PH_DY     = 4'd3,
    PH_ABS    = 4'd4,
    PH_ABSPAD = 4'd5,
    PH_RB0    = 4'd8,
    PH_RB1    = 4'd9,
    PH_RB2    = 4'd10,
    PH_RPAD   = 4'd11
  } phase_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_EXEC,
    S_RUN,
    S_RDA,
    S_RDD,
    S_OUT
  } state_e;

  function automatic logic [15:0] to565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* hw/rtl/bmprle_ram.sv */
// ----------------------------------------------------------------------------
// bmprle_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bmprle_ram #(
  parameter int unsigned W  = 16,
  parameter int unsigned D  = 256,
  parameter int unsigned AW = $clog2(D)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bmp_rle8_line_decoder.sv */
// ----------------------------------------------------------------------------
// bmp_rle8_line_decoder
// Decodes RLE8 or raw 8/24-bit BMP pixel data into an RGB565 line store.
// ----------------------------------------------------------------------------
//   channel | handshake             | payload
//   in      | in_valid_i/in_ready_o | op, palette_index, red, green, blue,
//           |                       | data_byte, read_column
//   out     | out_valid_o/out_ready_i | line_ready, line_row, line_length,
//           |                       | pixel_color, image_done
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// from IDLE: palette write OUT; line read RDA, RDD, OUT; data byte DEC,
// EXEC, OUT, with RUN before OUT for the rest of an RLE run (one line store
// write per cycle); a data byte taken once the image is done goes straight
// to OUT. a start image, and a data byte that follows an end of line, first
// run a white fill of the whole line store; reset runs the same fill before
// the first item is taken. a result waits in the output register while the
// next item is taken; a stalled output holds the following result.
module bmp_rle8_line_decoder #(
  parameter int unsigned DISPLAY_WIDTH  = bmprle_pkg::DISPLAY_WIDTH_DEF,
  parameter int unsigned DISPLAY_HEIGHT = bmprle_pkg::DISPLAY_HEIGHT_DEF,
  parameter int unsigned PALETTE_DEPTH  = bmprle_pkg::PALETTE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  palette_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  data_byte_i,
  input  logic [8:0]  read_column_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        line_ready_o,
  output logic [8:0]  line_row_o,
  output logic [8:0]  line_length_o,
  output logic [15:0] pixel_color_o,
  output logic        image_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(DISPLAY_WIDTH);
  localparam int unsigned PAW = $clog2(PALETTE_DEPTH);
  localparam logic [15:0] DW16 = 16'(DISPLAY_WIDTH);
  localparam logic [15:0] DH16 = 16'(DISPLAY_HEIGHT);

  // configuration
  logic [13:0] width_q, height_q;
  logic        tc_q, rle_q;

  // decode state
  bmprle_pkg::state_e state_q, state_d, tgt_q, tgt_d;
  bmprle_pkg::phase_e phase_q, phase_d, ph;
  logic [AW-1:0] clr_q, clr_d;
  logic [15:0]   col_q, col_d, col_inc;
  logic [15:0]   row_q, row_d;
  logic [13:0]   rows_q, rows_d, rows_inc;
  logic [7:0]    held_q, held_d, abs_q, abs_d, abs_dec;
  logic [15:0]   part_q, part_d;
  logic [1:0]    pad_q, pad_d, pad_dec, row_pad;
  logic          clrp_q, clrp_d, fin_q, fin_d;
  logic [7:0]    byte_q, byte_d;
  logic [8:0]    rcol_q, rcol_d;
  logic [7:0]    run_q, run_d;
  logic [15:0]   runc_q, runc_d;
  logic [13:0]   w_eff;
  logic          visible, do_put, row_end, ann;
  logic [15:0]   pc, ann_len;

  // pending result and output register
  logic        res_rdy_q, res_rdy_d;
  logic [8:0]  res_row_q, res_row_d, res_len_q, res_len_d;
  logic [15:0] res_pix_q, res_pix_d;
  logic        outv_q, outv_d, out_load;
  logic        o_rdy_q, o_fin_q;
  logic [8:0]  o_row_q, o_len_q;
  logic [15:0] o_pix_q;

  // memories
  logic            ls_we;
  logic [AW-1:0]   ls_waddr;
  logic [15:0]     ls_wdata, ls_rdata;
  logic            pal_we;
  logic [15:0]     pal_wdata, pal_rdata;

  bmprle_ram #(.W(16), .D(DISPLAY_WIDTH), .AW(AW)) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (ls_waddr),
    .wdata_i (ls_wdata),
    .raddr_i (AW'(rcol_q)),
    .rdata_o (ls_rdata)
  );

  bmprle_ram #(.W(16), .D(PALETTE_DEPTH), .AW(PAW)) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (PAW'(palette_index_i)),
    .wdata_i (pal_wdata),
    .raddr_i (PAW'(byte_q)),
    .rdata_o (pal_rdata)
  );

  assign pal_wdata = bmprle_pkg::to565(red_i, green_i, blue_i);

  function automatic logic [15:0] row_down(logic [15:0] r, logic [7:0] n);
    logic signed [16:0] t;
    t = $signed({r[15], r}) - $signed({9'b0, n});
    return (t < -17'sd1) ? 16'hFFFF : t[15:0];
  endfunction

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bmprle_pkg::WIDTH_RESET;
      height_q <= bmprle_pkg::HEIGHT_RESET;
      tc_q     <= 1'b0;
      rle_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (bmprle_pkg::cfg_e'(cfg_index_i))
        bmprle_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        bmprle_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        bmprle_pkg::CFG_TRUE:   tc_q     <= cfg_data_i[0];
        bmprle_pkg::CFG_RLE:    rle_q    <= cfg_data_i[0];
      endcase
    end
  end

  assign col_inc  = (col_q == bmprle_pkg::COL_MAX) ? col_q : col_q + 16'd1;
  assign rows_inc = (rows_q == bmprle_pkg::ROWS_MAX) ? rows_q : rows_q + 14'd1;
  assign abs_dec  = (abs_q != 8'd0) ? abs_q - 8'd1 : 8'd0;
  assign pad_dec  = (pad_q != 2'd0) ? pad_q - 2'd1 : 2'd0;
  assign w_eff    = (width_q == 14'd0) ? 14'd1 : width_q;
  // row padding: 3w bytes pad to w mod 4, w bytes pad to -w mod 4
  assign row_pad  = tc_q ? w_eff[1:0] : 2'(~w_eff[1:0] + 2'd1);
  assign visible  = !row_q[15] && (row_q < DH16);
  assign out_load = (state_q == bmprle_pkg::S_OUT) && (!outv_q || out_ready_i);

  // effective phase after a mode change
  always_comb begin
    ph = phase_q;
    if (rle_q) begin
      if (phase_q >= bmprle_pkg::PH_RB0) ph = bmprle_pkg::PH_FIRST;
    end else if (phase_q < bmprle_pkg::PH_RB0) begin
      ph = bmprle_pkg::PH_RB0;
    end else if (!tc_q && (phase_q == bmprle_pkg::PH_RB1 || phase_q == bmprle_pkg::PH_RB2)) begin
      ph = bmprle_pkg::PH_RB0;
    end
  end

  always_comb begin
    state_d   = state_q;
    tgt_d     = tgt_q;
    phase_d   = phase_q;
    clr_d     = clr_q;
    col_d     = col_q;
    row_d     = row_q;
    rows_d    = rows_q;
    held_d    = held_q;
    abs_d     = abs_q;
    part_d    = part_q;
    pad_d     = pad_q;
    clrp_d    = clrp_q;
    fin_d     = fin_q;
    byte_d    = byte_q;
    rcol_d    = rcol_q;
    run_d     = run_q;
    runc_d    = runc_q;
    res_rdy_d = res_rdy_q;
    res_row_d = res_row_q;
    res_len_d = res_len_q;
    res_pix_d = res_pix_q;
    in_ready_o = 1'b0;
    pal_we    = 1'b0;
    ls_we     = 1'b0;
    ls_waddr  = clr_q;
    ls_wdata  = bmprle_pkg::WHITE565;
    do_put    = 1'b0;
    pc        = pal_rdata;
    row_end   = 1'b0;
    ann       = 1'b0;
    ann_len   = col_q;

    unique case (state_q)
      bmprle_pkg::S_CLEAR: begin
        ls_we = 1'b1;
        if (clr_q == AW'(DISPLAY_WIDTH - 1)) begin
          clr_d   = '0;
          state_d = tgt_q;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      bmprle_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_rdy_d = 1'b0;
          res_row_d = '0;
          res_len_d = '0;
          res_pix_d = '0;
          byte_d    = data_byte_i;
          rcol_d    = read_column_i;
          unique case (bmprle_pkg::op_e'(op_i))
            bmprle_pkg::OP_START: begin
              col_d   = '0;
              row_d   = {2'b0, height_q} - 16'd1;
              rows_d  = '0;
              phase_d = rle_q ? bmprle_pkg::PH_FIRST : bmprle_pkg::PH_RB0;
              held_d  = '0;
              abs_d   = '0;
              part_d  = '0;
              pad_d   = '0;
              clrp_d  = 1'b0;
              fin_d   = !rle_q && (height_q == 14'd0);
              clr_d   = '0;
              tgt_d   = bmprle_pkg::S_OUT;
              state_d = bmprle_pkg::S_CLEAR;
            end
            bmprle_pkg::OP_PALETTE: begin
              pal_we  = 1'b1;
              state_d = bmprle_pkg::S_OUT;
            end
            bmprle_pkg::OP_DATA: begin
              if (fin_q) begin
                state_d = bmprle_pkg::S_OUT;
              end else if (clrp_q) begin
                clrp_d  = 1'b0;
                clr_d   = '0;
                tgt_d   = bmprle_pkg::S_DEC;
                state_d = bmprle_pkg::S_CLEAR;
              end else begin
                state_d = bmprle_pkg::S_DEC;
              end
            end
            bmprle_pkg::OP_READ: state_d = bmprle_pkg::S_RDA;
          endcase
        end
      end
      bmprle_pkg::S_DEC: state_d = bmprle_pkg::S_EXEC;
      bmprle_pkg::S_EXEC: begin
        state_d = bmprle_pkg::S_OUT;
        phase_d = ph;
        unique case (ph)
          bmprle_pkg::PH_FIRST: begin
            held_d  = byte_q;
            phase_d = bmprle_pkg::PH_SECOND;
          end
          bmprle_pkg::PH_SECOND: begin
            phase_d = bmprle_pkg::PH_FIRST;
            if (held_q != 8'd0) begin
              do_put = 1'b1;
              col_d  = col_inc;
              runc_d = pal_rdata;
              run_d  = held_q - 8'd1;
              if (held_q != 8'd1) state_d = bmprle_pkg::S_RUN;
            end else if (byte_q == 8'd0 || byte_q == 8'd1) begin
              ann = visible && (col_q != 16'd0);
              if (byte_q == 8'd0) begin
                col_d  = '0;
                row_d  = row_down(row_q, 8'd1);
                clrp_d = 1'b1;
              end else begin
                fin_d = 1'b1;
              end
            end else if (byte_q == 8'd2) begin
              phase_d = bmprle_pkg::PH_DX;
            end else begin
              abs_d   = byte_q;
              pad_d   = {1'b0, byte_q[0]};
              phase_d = bmprle_pkg::PH_ABS;
            end
          end
          bmprle_pkg::PH_DX: begin
            col_d   = ({1'b0, col_q} + {9'b0, byte_q} > 17'h0FFFF) ?
                      bmprle_pkg::COL_MAX : col_q + {8'b0, byte_q};
            phase_d = bmprle_pkg::PH_DY;
          end
          bmprle_pkg::PH_DY: begin
            row_d   = row_down(row_q, byte_q);
            phase_d = bmprle_pkg::PH_FIRST;
          end
          bmprle_pkg::PH_ABS: begin
            do_put = 1'b1;
            col_d  = col_inc;
            abs_d  = abs_dec;
            if (abs_dec == 8'd0)
              phase_d = (pad_q != 2'd0) ? bmprle_pkg::PH_ABSPAD : bmprle_pkg::PH_FIRST;
          end
          bmprle_pkg::PH_RB0, bmprle_pkg::PH_RB2: begin
            if (ph == bmprle_pkg::PH_RB0 && tc_q) begin
              part_d  = {8'b0, byte_q};
              phase_d = bmprle_pkg::PH_RB1;
            end else begin
              // finished pixel: palette index or last byte of bgr
              if (ph == bmprle_pkg::PH_RB2)
                pc = bmprle_pkg::to565(byte_q, part_q[15:8], part_q[7:0]);
              do_put  = 1'b1;
              col_d   = col_inc;
              phase_d = bmprle_pkg::PH_RB0;
              if (col_inc >= {2'b0, w_eff}) begin
                if (row_pad != 2'd0) begin
                  pad_d   = row_pad;
                  phase_d = bmprle_pkg::PH_RPAD;
                end else begin
                  row_end = 1'b1;
                end
              end
            end
          end
          bmprle_pkg::PH_RB1: begin
            part_d  = {byte_q, part_q[7:0]};
            phase_d = bmprle_pkg::PH_RB2;
          end
          bmprle_pkg::PH_RPAD: begin
            pad_d = pad_dec;
            if (pad_dec == 2'd0) row_end = 1'b1;
          end
          default: begin
            pad_d   = '0;
            phase_d = bmprle_pkg::PH_FIRST;
          end
        endcase
        if (row_end) begin
          ann     = visible;
          ann_len = {2'b0, w_eff};
          col_d   = '0;
          row_d   = row_down(row_q, 8'd1);
          clrp_d  = 1'b1;
          rows_d  = rows_inc;
          phase_d = bmprle_pkg::PH_RB0;
          if (rows_inc >= height_q) fin_d = 1'b1;
        end
        if (ann) begin
          res_rdy_d = 1'b1;
          res_row_d = row_q[8:0];
          res_len_d = (ann_len > DW16) ? DW16[8:0] : ann_len[8:0];
        end
      end
      bmprle_pkg::S_RUN: begin
        do_put = 1'b1;
        pc     = runc_q;
        col_d  = col_inc;
        run_d  = run_q - 8'd1;
        if (run_q == 8'd1) state_d = bmprle_pkg::S_OUT;
      end
      bmprle_pkg::S_RDA: state_d = bmprle_pkg::S_RDD;
      bmprle_pkg::S_RDD: begin
        res_pix_d = ({7'b0, rcol_q} < DW16) ? ls_rdata : 16'd0;
        state_d   = bmprle_pkg::S_OUT;
      end
      bmprle_pkg::S_OUT: begin
        if (out_load) state_d = bmprle_pkg::S_IDLE;
      end
    endcase

    // pixels past the display edge are dropped
    if (do_put && (col_q < DW16)) begin
      ls_we    = 1'b1;
      ls_waddr = col_q[AW-1:0];
      ls_wdata = pc;
    end
  end

  always_comb begin
    outv_d = outv_q;
    if (out_load) begin
      outv_d = 1'b1;
    end else if (out_ready_i) begin
      outv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmprle_pkg::S_CLEAR;
      tgt_q   <= bmprle_pkg::S_IDLE;
      phase_q <= bmprle_pkg::PH_RB0;
      clr_q   <= '0;
      col_q   <= '0;
      row_q   <= {2'b0, bmprle_pkg::HEIGHT_RESET} - 16'd1;
      rows_q  <= '0;
      held_q  <= '0;
      abs_q   <= '0;
      part_q  <= '0;
      pad_q   <= '0;
      clrp_q  <= 1'b0;
      fin_q   <= 1'b0;
      run_q   <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tgt_q   <= tgt_d;
      phase_q <= phase_d;
      clr_q   <= clr_d;
      col_q   <= col_d;
      row_q   <= row_d;
      rows_q  <= rows_d;
      held_q  <= held_d;
      abs_q   <= abs_d;
      part_q  <= part_d;
      pad_q   <= pad_d;
      clrp_q  <= clrp_d;
      fin_q   <= fin_d;
      run_q   <= run_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    rcol_q    <= rcol_d;
    runc_q    <= runc_d;
    res_rdy_q <= res_rdy_d;
    res_row_q <= res_row_d;
    res_len_q <= res_len_d;
    res_pix_q <= res_pix_d;
    if (out_load) begin
      o_rdy_q <= res_rdy_q;
      o_row_q <= res_row_q;
      o_len_q <= res_len_q;
      o_pix_q <= res_pix_q;
      o_fin_q <= fin_q;
    end
  end

  assign out_valid_o   = outv_q;
  assign line_ready_o  = o_rdy_q;
  assign line_row_o    = o_row_q;
  assign line_length_o = o_len_q;
  assign pixel_color_o = o_pix_q;
  assign image_done_o  = o_fin_q;

endmodule

/* tb/sv/bmp_rle8_line_checker.sv */
// ----------------------------------------------------------------------------
// bmp_rle8_line_checker
// Watches the input, output and register channels of the line decoder,
// predicts every result from its own copy of the decoder state and compares.
// ----------------------------------------------------------------------------
module bmp_rle8_line_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  palette_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  data_byte_i,
  input  logic [8:0]  read_column_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        line_ready_i,
  input  logic [8:0]  line_row_i,
  input  logic [8:0]  line_length_i,
  input  logic [15:0] pixel_color_i,
  input  logic        image_done_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = int'(bmprle_pkg::DISPLAY_WIDTH_DEF);
  localparam int DH = int'(bmprle_pkg::DISPLAY_HEIGHT_DEF);

  typedef struct packed {
    logic        line_ready;
    logic [8:0]  line_row;
    logic [8:0]  line_length;
    logic [15:0] pixel_color;
    logic        image_done;
  } line_result_t;

  line_result_t expected_q[$];

  logic [13:0] img_w, img_h;
  logic        true_c, rle_m;
  logic [15:0] store[DW];
  logic [15:0] pal[256];
  int          col, row, rows_cnt, held, abs_left, pad_left;
  logic [15:0] partial;
  bmprle_pkg::phase_e phase;
  logic        clr_pend, fin;

  function automatic logic [15:0] rgb565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  task automatic whiten();
    for (int i = 0; i < DW; i++) store[i] = bmprle_pkg::WHITE565;
  endtask

  task automatic restart_image();
    col = 0; row = int'(img_h) - 1; rows_cnt = 0;
    phase = rle_m ? bmprle_pkg::PH_FIRST : bmprle_pkg::PH_RB0;
    held = 0; abs_left = 0; partial = '0; pad_left = 0;
    clr_pend = 1'b0;
    fin = !rle_m && img_h == 14'd0;
    whiten();
  endtask

  task automatic put_px(logic [15:0] c);
    if (col < DW) store[col] = c;
    if (col < 65535) col++;
  endtask

  task automatic go_down(int n);
    row = (row - n < -1) ? -1 : row - n;
  endtask

  task automatic announce(inout line_result_t r, input int len);
    r.line_ready  = 1'b1;
    r.line_row    = row[8:0];
    r.line_length = (len > DW) ? 9'(DW) : 9'(len);
  endtask

  function automatic bit on_screen();
    return row >= 0 && row < DH;
  endfunction

  task automatic raw_end(inout line_result_t r, input int w);
    if (on_screen()) announce(r, w);
    col = 0; go_down(1); clr_pend = 1'b1;
    if (rows_cnt < 16383) rows_cnt++;
    phase = bmprle_pkg::PH_RB0;
    if (rows_cnt >= int'(img_h)) fin = 1'b1;
  endtask

  task automatic raw_px(inout line_result_t r, input logic [15:0] c, input int w);
    int pad;
    put_px(c);
    phase = bmprle_pkg::PH_RB0;
    if (col >= w) begin
      pad = (0 - w * (true_c ? 3 : 1)) & 3;
      if (pad > 0) begin
        pad_left = pad; phase = bmprle_pkg::PH_RPAD;
      end else begin
        raw_end(r, w);
      end
    end
  endtask

  task automatic decode_byte(inout line_result_t r, input logic [7:0] b);
    int w;
    bit rle_ph;
    rle_ph = phase < bmprle_pkg::PH_RB0;
    if (clr_pend) begin
      whiten(); clr_pend = 1'b0;
    end
    if (rle_m) begin
      if (!rle_ph) phase = bmprle_pkg::PH_FIRST;
      case (phase)
        bmprle_pkg::PH_FIRST: begin
          held = int'(b); phase = bmprle_pkg::PH_SECOND;
        end
        bmprle_pkg::PH_SECOND: begin
          phase = bmprle_pkg::PH_FIRST;
          if (held > 0) begin
            for (int i = 0; i < held; i++) put_px(pal[b]);
          end else if (b == 8'd0 || b == 8'd1) begin
            if (on_screen() && col > 0) announce(r, col);
            if (b == 8'd0) begin
              col = 0; go_down(1); clr_pend = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end else if (b == 8'd2) begin
            phase = bmprle_pkg::PH_DX;
          end else begin
            abs_left = int'(b); pad_left = int'(b[0]); phase = bmprle_pkg::PH_ABS;
          end
        end
        bmprle_pkg::PH_DX: begin
          col = (col + int'(b) > 65535) ? 65535 : col + int'(b);
          phase = bmprle_pkg::PH_DY;
        end
        bmprle_pkg::PH_DY: begin
          go_down(int'(b)); phase = bmprle_pkg::PH_FIRST;
        end
        bmprle_pkg::PH_ABS: begin
          put_px(pal[b]);
          if (abs_left > 0) abs_left--;
          if (abs_left == 0)
            phase = (pad_left != 0) ? bmprle_pkg::PH_ABSPAD : bmprle_pkg::PH_FIRST;
        end
        default: begin
          pad_left = 0; phase = bmprle_pkg::PH_FIRST;
        end
      endcase
    end else begin
      if (rle_ph) phase = bmprle_pkg::PH_RB0;
      w = (img_w != 14'd0) ? int'(img_w) : 1;
      if (!true_c && (phase == bmprle_pkg::PH_RB1 || phase == bmprle_pkg::PH_RB2))
        phase = bmprle_pkg::PH_RB0;
      case (phase)
        bmprle_pkg::PH_RB0: begin
          if (true_c) begin
            partial = {8'h00, b}; phase = bmprle_pkg::PH_RB1;
          end else begin
            raw_px(r, pal[b], w);
          end
        end
        bmprle_pkg::PH_RB1: begin
          partial = {b, partial[7:0]}; phase = bmprle_pkg::PH_RB2;
        end
        bmprle_pkg::PH_RB2: raw_px(r, rgb565(b, partial[15:8], partial[7:0]), w);
        default: begin
          if (pad_left > 0) pad_left--;
          if (pad_left == 0) raw_end(r, w);
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t r, got, exp_r;
    if (!rst_ni) begin
      img_w = bmprle_pkg::WIDTH_RESET; img_h = bmprle_pkg::HEIGHT_RESET;
      true_c = 1'b0; rle_m = 1'b0;
      for (int i = 0; i < 256; i++) pal[i] = '0;
      restart_image();
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{line_ready_i, line_row_i, line_length_i, pixel_color_i, image_done_i};
        if (expected_q.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.line_ready !== exp_r.line_ready) begin
            $error("line_ready expected %0d actual %0d", exp_r.line_ready, got.line_ready);
            fail_count_o++;
          end
          if (got.line_row !== exp_r.line_row) begin
            $error("line_row expected %0d actual %0d", exp_r.line_row, got.line_row);
            fail_count_o++;
          end
          if (got.line_length !== exp_r.line_length) begin
            $error("line_length expected %0d actual %0d", exp_r.line_length,
                   got.line_length);
            fail_count_o++;
          end
          if (got.pixel_color !== exp_r.pixel_color) begin
            $error("pixel_color expected %h actual %h", exp_r.pixel_color,
                   got.pixel_color);
            fail_count_o++;
          end
          if (got.image_done !== exp_r.image_done) begin
            $error("image_done expected %0d actual %0d", exp_r.image_done, got.image_done);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (bmprle_pkg::cfg_e'(cfg_index_i))
          bmprle_pkg::CFG_WIDTH:  img_w = cfg_data_i;
          bmprle_pkg::CFG_HEIGHT: img_h = cfg_data_i;
          bmprle_pkg::CFG_TRUE:   true_c = cfg_data_i[0];
          bmprle_pkg::CFG_RLE:    rle_m = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        r = '0;
        case (bmprle_pkg::op_e'(op_i))
          bmprle_pkg::OP_START:   restart_image();
          bmprle_pkg::OP_PALETTE: pal[palette_index_i] = rgb565(red_i, green_i, blue_i);
          bmprle_pkg::OP_DATA:    if (!fin) decode_byte(r, data_byte_i);
          default: begin
            if (int'(read_column_i) < DW) r.pixel_color = store[read_column_i];
          end
        endcase
        r.image_done = fin;
        expected_q.push_back(r);
      end
    end
    pending_o = expected_q.size();
  end
endmodule

/* tb/sv/bmp_rle8_line_decoder_tb.sv */
// ----------------------------------------------------------------------------
// bmp_rle8_line_decoder_tb
// Drives palette loads, RLE8 and raw streams and line reads into the decoder
// under random idling, across several image settings; the checker compares.
// ----------------------------------------------------------------------------
module bmp_rle8_line_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [7:0]  palette_index_i = '0, red_i = '0, green_i = '0, blue_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [8:0]  read_column_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        line_ready_o, image_done_o;
  logic [8:0]  line_row_o, line_length_o;
  logic [15:0] pixel_color_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [13:0] cfg_data_i = '0;
  int          fail_count, pending;
  bit          calm = 1'b0;
  int          item_count = 0;

  always #10 clk_i = ~clk_i;

  bmp_rle8_line_decoder DUT (.*);

  bmp_rle8_line_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .palette_index_i,
    .red_i, .green_i, .blue_i, .data_byte_i, .read_column_i,
    .out_valid_i(out_valid_o), .out_ready_i, .line_ready_i(line_ready_o),
    .line_row_i(line_row_o), .line_length_i(line_length_o),
    .pixel_color_i(pixel_color_o), .image_done_i(image_done_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [8:0] rnd9();
    return 9'($urandom);
  endfunction

  // receiver stalls in bursts
  initial begin
    int n;
    @(negedge clk_i);
    forever begin
      out_ready_i = 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i = 1'b0;
        n = $urandom_range(1, 4);
        repeat (n) @(negedge clk_i);
      end
    end
  end

  task automatic send(bmprle_pkg::op_e op, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                      logic [7:0] d, logic [7:0] db, logic [8:0] rc);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) @(negedge clk_i);
    end
    in_valid_i = 1'b1; op_i = op; palette_index_i = a; red_i = b; green_i = c;
    blue_i = d; data_byte_i = db; read_column_i = rc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    item_count++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic data(logic [7:0] b);
    send(bmprle_pkg::OP_DATA, rnd8(), rnd8(), rnd8(), rnd8(), b, rnd9());
  endtask

  task automatic read_px(logic [8:0] c);
    send(bmprle_pkg::OP_READ, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), c);
  endtask

  task automatic start_img();
    send(bmprle_pkg::OP_START, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd9());
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (1200) @(negedge clk_i);
  endtask

  // registers change only with nothing in flight
  task automatic set_reg(bmprle_pkg::cfg_e idx, logic [13:0] v);
    while (pending != 0) @(negedge clk_i);
    cfg_valid_i = 1'b1; cfg_index_i = idx; cfg_data_i = v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic setup(logic [13:0] w, logic [13:0] h, bit tc, bit rle);
    drain();
    set_reg(bmprle_pkg::CFG_WIDTH, w); set_reg(bmprle_pkg::CFG_HEIGHT, h);
    set_reg(bmprle_pkg::CFG_TRUE, {13'b0, tc}); set_reg(bmprle_pkg::CFG_RLE, {13'b0, rle});
    start_img();
  endtask

  // one random command of a phase, mostly well-formed rle commands or raw bytes
  task automatic random_rle_cmd();
    int k;
    logic [7:0] n;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      data(8'($urandom_range(1, 40))); data(rnd8());
    end else if (k < 60) begin
      data(8'd0); data(8'd0);
    end else if (k < 70) begin
      n = 8'($urandom_range(3, 12));
      data(8'd0); data(n);
      for (int i = 0; i < int'(n); i++) data(rnd8());
      if (n[0]) data(rnd8());
    end else if (k < 76) begin
      data(8'd0); data(8'd2); data(8'($urandom_range(0, 30))); data(8'($urandom_range(0, 3)));
    end else if (k < 78) begin
      data(8'd0); data(8'd1);
    end else if (k < 90) begin
      read_px(rnd9());
    end else if (k < 94) begin
      send(bmprle_pkg::OP_PALETTE, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd9());
    end else if (k < 97) begin
      data(rnd8());
    end else begin
      start_img();
    end
  endtask

  task automatic random_raw_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) data(rnd8());
    else if (k < 92) read_px(rnd9());
    else if (k < 97) send(bmprle_pkg::OP_PALETTE, rnd8(), rnd8(), rnd8(), rnd8(),
                          rnd8(), rnd9());
    else start_img();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    // every palette entry is written so no read of an unset entry can occur
    for (int i = 0; i < 256; i++)
      send(bmprle_pkg::OP_PALETTE, 8'(i), rnd8(), rnd8(), rnd8(), rnd8(), rnd9());
    send(bmprle_pkg::OP_PALETTE, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 9'd0);
    send(bmprle_pkg::OP_PALETTE, 8'd255, 8'h00, 8'h00, 8'h00, 8'hFF, 9'd511);

    // directed rle: run, absolute odd and even, delta, end of line, end of bitmap
    setup(14'd8, 14'd4, 1'b0, 1'b1);
    data(8'd255); data(8'd7);
    data(8'd0); data(8'd3); data(8'd1); data(8'd2); data(8'd3); data(8'd0);
    data(8'd0); data(8'd4); data(8'd4); data(8'd5); data(8'd6); data(8'd7);
    data(8'd0); data(8'd2); data(8'd255); data(8'd1);
    data(8'd0); data(8'd0);
    read_px(9'd0); read_px(9'd479); read_px(9'd480); read_px(9'd511);
    data(8'd0); data(8'd0);
    data(8'd0); data(8'd1);
    data(8'd9);
    // pause until every result has come back
    while (pending != 0) @(negedge clk_i);
    setup(14'd8, 14'd400, 1'b0, 1'b1);
    data(8'd0); data(8'd2); data(8'd0); data(8'd255);
    data(8'd1); data(8'd1); data(8'd0); data(8'd0);
    // raw zero height and zero width, then a mode change mid-stream
    setup(14'd0, 14'd0, 1'b1, 1'b0);
    data(8'd1);
    setup(14'd0, 14'd2, 1'b0, 1'b0);
    data(8'd1); data(8'd2); data(8'd3); data(8'd4); data(8'd5);
    setup(14'd5, 14'd3, 1'b1, 1'b0);
    data(8'hFF); data(8'h00);
    set_reg(bmprle_pkg::CFG_TRUE, 14'd0);
    data(8'h80);
    set_reg(bmprle_pkg::CFG_RLE, 14'd1);
    data(8'd2); data(8'd3);
    set_reg(bmprle_pkg::CFG_RLE, 14'd0);
    data(8'd4);

    for (int ph = 0; item_count < 1850; ph++) begin
      case (ph % 6)
        0: setup(14'($urandom_range(1, 40)), 14'($urandom_range(1, 30)), 1'b0, 1'b1);
        1: setup(14'($urandom_range(1, 7)), 14'($urandom_range(1, 12)), 1'b0, 1'b0);
        2: setup(14'($urandom_range(1, 7)), 14'($urandom_range(1, 12)), 1'b1, 1'b0);
        3: setup(14'd8192, 14'd8192, 1'b0, 1'b1);
        4: setup(14'd1, 14'd1, 1'($urandom_range(0, 1)), 1'b0);
        default: setup(14'd500, 14'($urandom_range(318, 330)), 1'b0, 1'b1);
      endcase
      if (item_count > 1650) calm = 1'b1;
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(0, 1) == 1 && (ph % 6) != 1 && (ph % 6) != 2 && (ph % 6) != 4)
          random_rle_cmd();
        else if ((ph % 6) == 0 || (ph % 6) == 3 || (ph % 6) == 5)
          random_rle_cmd();
        else
          random_raw_item();
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("bmp_rle8_line_decoder test passed");
    end else begin
      $display("bmp_rle8_line_decoder test failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("bmp_rle8_line_decoder test failed");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/bmprle_pkg.sv
hw/rtl/bmprle_ram.sv
hw/rtl/bmp_rle8_line_decoder.sv
tb/sv/bmp_rle8_line_checker.sv
tb/sv/bmp_rle8_line_decoder_tb.sv
